// File: src/iwws_pkg.sv
`timescale 1ns / 1ps

package iwws_pkg;

   localparam int unsigned MODE_BITS  = 2;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned INDEX_BITS = 12;
   localparam int unsigned BITCNT_BITS = 3;
   localparam logic [BITCNT_BITS-1:0] LAST_BIT = 3'd7;

   typedef enum logic [3:0] {
      STEP_START_SDA_HI = 4'd0,
      STEP_START_SCL_HI = 4'd1,
      STEP_START_SDA_LO = 4'd2,
      STEP_START_SCL_LO = 4'd3,
      STEP_BIT_SDA      = 4'd4,
      STEP_BIT_SCL_HI   = 4'd5,
      STEP_BIT_SCL_LO   = 4'd6,
      STEP_ACK_SDA_HI   = 4'd7,
      STEP_ACK_SCL_HI   = 4'd8,
      STEP_ACK_SCL_LO   = 4'd9,
      STEP_ACK_HOLD     = 4'd10,
      STEP_STOP_SDA_LO  = 4'd11,
      STEP_STOP_SCL_HI  = 4'd12,
      STEP_STOP_SDA_HI  = 4'd13
   } step_type;

   typedef enum logic [1:0] {
      JMP_NEXT      = 2'd0,
      JMP_BIT_LOOP  = 2'd1,
      JMP_END_NSTOP = 2'd2,
      JMP_END       = 2'd3
   } jump_type;

   typedef struct packed {
      logic     set_sda;
      logic     set_scl;
      logic     use_bit;
      logic     level;
      logic     drive;
      jump_type jump;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic load;
      logic fire;
      logic set_sda;
      logic set_scl;
      logic use_bit;
      logic level;
      logic drive;
      logic last;
   } ctrl_type;

   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      w = '{set_sda: 1'b0, set_scl: 1'b0, use_bit: 1'b0, level: 1'b0,
            drive: 1'b1, jump: JMP_END, target: STEP_START_SDA_HI};
      unique case (step)
         STEP_START_SDA_HI: begin
            w.set_sda = 1'b1; w.level = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_START_SCL_HI: begin
            w.set_scl = 1'b1; w.level = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_START_SDA_LO: begin
            w.set_sda = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_START_SCL_LO: begin
            w.set_scl = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_BIT_SDA: begin
            w.set_sda = 1'b1; w.use_bit = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_BIT_SCL_HI: begin
            w.set_scl = 1'b1; w.level = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_BIT_SCL_LO: begin
            w.set_scl = 1'b1; w.jump = JMP_BIT_LOOP; w.target = STEP_BIT_SDA;
         end
         STEP_ACK_SDA_HI: begin
            w.set_sda = 1'b1; w.level = 1'b1; w.drive = 1'b0; w.jump = JMP_NEXT;
         end
         STEP_ACK_SCL_HI: begin
            w.set_scl = 1'b1; w.level = 1'b1; w.drive = 1'b0; w.jump = JMP_NEXT;
         end
         STEP_ACK_SCL_LO: begin
            w.set_scl = 1'b1; w.drive = 1'b0; w.jump = JMP_NEXT;
         end
         STEP_ACK_HOLD: begin
            w.set_scl = 1'b1; w.drive = 1'b0; w.jump = JMP_END_NSTOP;
         end
         STEP_STOP_SDA_LO: begin
            w.set_sda = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_STOP_SCL_HI: begin
            w.set_scl = 1'b1; w.level = 1'b1; w.jump = JMP_NEXT;
         end
         STEP_STOP_SDA_HI: begin
            w.set_sda = 1'b1; w.level = 1'b1; w.jump = JMP_END;
         end
         default: begin
            w.jump = JMP_END;
         end
      endcase
      return w;
   endfunction

endpackage

// File: src/i2c_write_waveform_sequencer.sv
`timescale 1ns / 1ps

// I2C master write waveform sequencer. Each request item carries one byte in
// req_tdata and a mode in req_tuser (bit 0: START before the byte, bit 1: STOP
// after it). The block answers with 28 to 35 response items, one waveform row
// each: the running row number, the SCL and SDA levels and the SDA drive flag,
// with rsp_tlast on the final row of the item. A read-only microcode table
// steps through START (4 rows), eight data bits MSB first (3 rows each), the
// acknowledge slot with SDA released (4 rows, never sampled) and STOP (3 rows).
// One row is produced per cycle while the response side takes them. The block
// takes the request and then produces its rows in order; the next request is
// taken once the final row of the current one sits in the output register. The
// row number wraps modulo 2**ROW_BITS and is shown in its low 12 bits.

module i2c_write_waveform_sequencer #(
   parameter int unsigned ROW_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] tx_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] row_index, [12] clock_line,
                                    // [13] data_line, [14] data_drive, [15] zero
   output logic        rsp_tlast    // last_row
);
   import iwws_pkg::*;

   ctrl_type              ctrl;
   logic                  out_free;
   logic [INDEX_BITS-1:0] row_index;
   logic                  clock_line;
   logic                  data_line;
   logic                  data_drive;

   iwws_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .out_free   (out_free),
      .ctrl       (ctrl)
   );

   iwws_datapath #(
      .ROW_BITS (ROW_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .tx_byte    (req_tdata),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .row_index  (row_index),
      .clock_line (clock_line),
      .data_line  (data_line),
      .data_drive (data_drive),
      .last_row   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, data_drive, data_line, clock_line, row_index};

endmodule

// File: src/iwws_sequencer.sv
`timescale 1ns / 1ps

module iwws_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [iwws_pkg::MODE_BITS-1:0]      req_mode,
   input  logic                                out_free,
   output iwws_pkg::ctrl_type                  ctrl
);
   import iwws_pkg::*;

   logic                   busy_ff, busy_in;
   step_type               step_ff, step_in;
   logic [BITCNT_BITS-1:0] bit_ff, bit_in;
   logic                   stop_ff, stop_in;
   logic                   accept;
   logic                   advance;
   uword_type              word;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign advance    = busy_ff && out_free;
   assign word       = ucode_rom(step_ff);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      bit_in  = bit_ff;
      stop_in = stop_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = req_mode[0] ? STEP_START_SDA_HI : STEP_BIT_SDA;
         bit_in  = '0;
         stop_in = req_mode[1];
      end else if (advance) begin
         unique case (word.jump)
            JMP_NEXT: begin
               step_in = step_type'(step_ff + 4'd1);
            end
            JMP_BIT_LOOP: begin
               if (bit_ff == LAST_BIT) begin
                  step_in = step_type'(step_ff + 4'd1);
                  bit_in  = '0;
               end else begin
                  step_in = word.target;
                  bit_in  = bit_ff + 3'd1;
               end
            end
            JMP_END_NSTOP: begin
               if (stop_ff) begin
                  step_in = step_type'(step_ff + 4'd1);
               end else begin
                  busy_in = 1'b0;
               end
            end
            JMP_END: begin
               busy_in = 1'b0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_START_SDA_HI;
         bit_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         bit_ff  <= bit_in;
         stop_ff <= stop_in;
      end
   end

   always_comb begin
      ctrl.load    = accept;
      ctrl.fire    = advance;
      ctrl.set_sda = word.set_sda;
      ctrl.set_scl = word.set_scl;
      ctrl.use_bit = word.use_bit;
      ctrl.level   = word.level;
      ctrl.drive   = word.drive;
      ctrl.last    = (word.jump == JMP_END) || ((word.jump == JMP_END_NSTOP) && !stop_ff);
   end

endmodule

// File: src/iwws_datapath.sv
`timescale 1ns / 1ps

module iwws_datapath #(
   parameter int unsigned ROW_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iwws_pkg::ctrl_type                  ctrl,
   input  logic [iwws_pkg::BYTE_BITS-1:0]      tx_byte,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [iwws_pkg::INDEX_BITS-1:0]     row_index,
   output logic                                clock_line,
   output logic                                data_line,
   output logic                                data_drive,
   output logic                                last_row
);
   import iwws_pkg::*;

   logic                             scl_ff, scl_in;
   logic                             sda_ff, sda_in;
   logic [BYTE_BITS-1:0]             shift_ff, shift_in;
   logic [ROW_BITS-1:0]              count_ff, count_in;
   logic                             valid_ff, valid_in;
   logic [INDEX_BITS-1:0]            index_ff;
   logic                             clk_line_ff;
   logic                             dat_line_ff;
   logic                             drive_ff;
   logic                             last_ff;
   logic [ROW_BITS+INDEX_BITS-1:0]   count_wide;

   assign out_free   = !valid_ff || rsp_tready;
   assign count_wide = {{INDEX_BITS{1'b0}}, count_ff};

   always_comb begin
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      valid_in = valid_ff && !rsp_tready;
      if (ctrl.load) begin
         shift_in = tx_byte;
      end
      if (ctrl.fire) begin
         if (ctrl.set_sda) begin
            sda_in = ctrl.use_bit ? shift_ff[BYTE_BITS-1] : ctrl.level;
         end
         if (ctrl.use_bit) begin
            shift_in = {shift_ff[BYTE_BITS-2:0], 1'b0};
         end
         if (ctrl.set_scl) begin
            scl_in = ctrl.level;
         end
         count_in = count_ff + ROW_BITS'(1);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (ctrl.fire) begin
         index_ff    <= count_wide[INDEX_BITS-1:0];
         clk_line_ff <= scl_in;
         dat_line_ff <= sda_in;
         drive_ff    <= ctrl.drive;
         last_ff     <= ctrl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign row_index  = index_ff;
   assign clock_line = clk_line_ff;
   assign data_line  = dat_line_ff;
   assign data_drive = drive_ff;
   assign last_row   = last_ff;

endmodule

// File: tb/tb_i2c_write_waveform_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_write_waveform_sequencer;

   import iwws_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_BYTE       = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_START      = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_STOP       = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_START_STOP = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 350;

   typedef struct packed {
      logic [INDEX_BITS-1:0] num;
      logic                  scl;
      logic                  sda;
      logic                  drive;
      logic                  last;
   } row_type;

   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic [BYTE_BITS-1:0] data;
      bit                   drain;
   } write_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_BITS-1:0]  req_tdata = '0;   // [7:0] tx_byte
   logic [MODE_BITS-1:0]  req_tuser = '0;   // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;        // [11:0] row_index, [12] clock_line,
                                            // [13] data_line, [14] data_drive, [15] zero
   logic                  rsp_tlast;

   write_item_type        pending_writes[$];
   row_type               expected_rows[$];
   int unsigned           total_writes = 0;
   int unsigned           sent_writes = 0;
   int unsigned           fail_count = 0;
   int unsigned           send_gap = 0;
   int unsigned           stall_left = 0;
   bit                    quiet = 1'b0;

   logic                  bus_scl = 1'b1;
   logic                  bus_sda = 1'b1;
   logic                  sda_owned = 1'b1;
   logic [INDEX_BITS-1:0] next_row = '0;

   i2c_write_waveform_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap(input int unsigned zero_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < zero_pct) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_row(input bit is_last);
      row_type r;
      r.num   = next_row;
      r.scl   = bus_scl;
      r.sda   = bus_sda;
      r.drive = sda_owned;
      r.last  = is_last;
      expected_rows.push_back(r);
      next_row = next_row + INDEX_BITS'(1);
   endtask

   task automatic sequence_write_rows(input logic [MODE_BITS-1:0] mode,
                                      input logic [BYTE_BITS-1:0] data);
      bit with_start;
      bit with_stop;
      with_start = (mode == MODE_START) || (mode == MODE_START_STOP);
      with_stop  = (mode == MODE_STOP) || (mode == MODE_START_STOP);
      if (with_start) begin
         bus_sda = 1'b1; push_row(1'b0);
         bus_scl = 1'b1; push_row(1'b0);
         bus_sda = 1'b0; push_row(1'b0);
         bus_scl = 1'b0; push_row(1'b0);
      end
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         bus_sda = data[i]; push_row(1'b0);
         bus_scl = 1'b1;    push_row(1'b0);
         bus_scl = 1'b0;    push_row(1'b0);
      end
      sda_owned = 1'b0;
      bus_sda = 1'b1; push_row(1'b0);
      bus_scl = 1'b1; push_row(1'b0);
      bus_scl = 1'b0; push_row(1'b0);
      bus_scl = 1'b0; push_row(!with_stop);
      sda_owned = 1'b1;
      if (with_stop) begin
         bus_sda = 1'b0; push_row(1'b0);
         bus_scl = 1'b1; push_row(1'b0);
         bus_sda = 1'b1; push_row(1'b1);
      end
   endtask

   task automatic check_row();
      row_type got;
      row_type want;
      got.num   = rsp_tdata[INDEX_BITS-1:0];
      got.scl   = rsp_tdata[12];
      got.sda   = rsp_tdata[13];
      got.drive = rsp_tdata[14];
      got.last  = rsp_tlast;
      if (expected_rows.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected row: num=%0d scl=%b sda=%b drive=%b last=%b",
                     got.num, got.scl, got.sda, got.drive, got.last);
      end else begin
         want = expected_rows.pop_front();
         if (got != want) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("row mismatch: expected num=%0d scl=%b sda=%b drive=%b last=%b",
                        want.num, want.scl, want.sda, want.drive, want.last);
               $display("              got      num=%0d scl=%b sda=%b drive=%b last=%b",
                        got.num, got.scl, got.sda, got.drive, got.last);
            end
         end
      end
   endtask

   task automatic queue_write(input logic [MODE_BITS-1:0] mode,
                              input logic [BYTE_BITS-1:0] data, input bit drain);
      write_item_type w;
      w.mode  = mode;
      w.data  = data;
      w.drain = drain;
      pending_writes.push_back(w);
      total_writes++;
   endtask

   always @(posedge clock) begin
      if (!reset && $urandom_range(0, 299) == 0) quiet <= !quiet;
   end

   always @(posedge clock) begin
      write_item_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sequence_write_rows(req_tuser, req_tdata);
            sent_writes++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_writes.size() != 0 &&
                         !(pending_writes[0].drain && expected_rows.size() != 0)) begin
               w = pending_writes.pop_front();
               req_tuser  <= w.mode;
               req_tdata  <= w.data;
               req_tvalid <= 1'b1;
               send_gap = pick_gap(55);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_row();
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_gap(80);
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   initial begin
      queue_write(MODE_BYTE,       8'hA5, 1'b0);
      queue_write(MODE_START,      8'h00, 1'b0);
      queue_write(MODE_START_STOP, 8'hFF, 1'b0);
      queue_write(MODE_STOP,       8'h80, 1'b0);
      queue_write(MODE_START,      8'h01, 1'b0);
      queue_write(MODE_START_STOP, 8'h55, 1'b0);
      queue_write(MODE_BYTE,       8'hAA, 1'b0);
      queue_write(MODE_STOP,       8'h7F, 1'b0);
      queue_write(MODE_START,      8'hFE, 1'b0);
      queue_write(MODE_BYTE,       8'hFF, 1'b0);
      queue_write(MODE_START_STOP, 8'h00, 1'b0);
      queue_write(MODE_STOP,       8'h00, 1'b0);
      queue_write(MODE_START_STOP, 8'hFF, 1'b0);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         queue_write(MODE_BITS'($urandom_range(0, 3)),
                     ($urandom_range(0, 99) < 15) ? {BYTE_BITS{$urandom_range(0, 1) == 1}}
                                                  : BYTE_BITS'($urandom_range(0, 255)),
                     n == 0 || n == RANDOM_ITEMS / 2);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (sent_writes != total_writes) @(posedge clock);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (expected_rows.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
